@@ rtl/complex_arithmetic_unit_defines.svh @@
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define CAU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cau_pkg.sv @@
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

    localparam int FIELD_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_EQ  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef struct packed {
        t_op  op;
        logic is_eq;
        logic b_zero;
        logic sat;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } t_ctrl;

endpackage

@@ rtl/cau_front.sv @@
// Front stages: operand capture, products, sums, magnitudes and divider setup.
module cau_front #(
    parameter int OPW       = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [cau_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [cau_pkg::FIELD_W-1:0]      i_a_re,
    input  logic [cau_pkg::FIELD_W-1:0]      i_a_im,
    input  logic [cau_pkg::FIELD_W-1:0]      i_b_re,
    input  logic [cau_pkg::FIELD_W-1:0]      i_b_im,
    output logic                             o_valid,
    output cau_pkg::t_ctrl                   o_ctrl,
    output logic signed [OPW-1:0]            o_cre,
    output logic signed [OPW-1:0]            o_cim,
    output logic [2*OPW-1:0]                 o_den,
    output logic [3*OPW+FRAC_BITS:0]         o_rem_re,
    output logic [3*OPW+FRAC_BITS:0]         o_rem_im,
    output logic [2*OPW-1:0]                 o_sq_s
);
    import cau_pkg::*;

    localparam int MW = 2 * OPW;
    localparam int QB = OPW + 1;
    localparam int XW = 2 * OPW + FRAC_BITS + QB;
    localparam logic [MW-1:0] POSLIM = {{(MW-OPW+1){1'b0}}, {(OPW-1){1'b1}}};
    localparam logic [MW-1:0] NEGLIM = {{(MW-OPW){1'b0}}, 1'b1, {(OPW-1){1'b0}}};

    function automatic logic signed [OPW-1:0] sat_sum(input logic signed [OPW:0] s);
        if (s[OPW] != s[OPW-1]) begin
            sat_sum = s[OPW] ? {1'b1, {(OPW-1){1'b0}}} : {1'b0, {(OPW-1){1'b1}}};
        end else begin
            sat_sum = s[OPW-1:0];
        end
    endfunction

    // Returns {saturated, value} for a sign and magnitude.
    function automatic logic [OPW:0] clamp_mag(input logic neg, input logic [MW-1:0] mag);
        logic [OPW-1:0] low;
        low = mag[OPW-1:0];
        if (!neg && mag > POSLIM) begin
            clamp_mag = {1'b1, POSLIM[OPW-1:0]};
        end else if (neg && mag > NEGLIM) begin
            clamp_mag = {1'b1, NEGLIM[OPW-1:0]};
        end else begin
            clamp_mag = {1'b0, neg ? -low : low};
        end
    endfunction

    // stage 1: operands
    logic                   r_s1_valid;
    t_op                    r_s1_op;
    logic signed [OPW-1:0]  r_s1_ar, r_s1_ai, r_s1_br, r_s1_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_op <= t_op'(i_opcode);
            r_s1_ar <= i_a_re[OPW-1:0];
            r_s1_ai <= i_a_im[OPW-1:0];
            r_s1_br <= i_b_re[OPW-1:0];
            r_s1_bi <= i_b_im[OPW-1:0];
        end
    end

    // stage 2: products, add/sub, compare
    logic                   r_s2_valid;
    t_ctrl                  r_s2_ctrl, n_s2_ctrl;
    logic signed [OPW-1:0]  r_s2_cre, r_s2_cim, n_s2_cre, n_s2_cim;
    logic signed [MW-1:0]   r_s2_p0, r_s2_p1, r_s2_p2, r_s2_p3, r_s2_p4, r_s2_p5;
    logic signed [MW-1:0]   n_s2_p0, n_s2_p1, n_s2_p2, n_s2_p3, n_s2_p4, n_s2_p5;
    logic signed [OPW-1:0]  sq_x, sq_y;
    logic signed [OPW:0]    sum_re, sum_im, dif_re, dif_im;

    assign sq_x    = (r_s1_op == OP_MOD) ? r_s1_ar : r_s1_br;
    assign sq_y    = (r_s1_op == OP_MOD) ? r_s1_ai : r_s1_bi;
    assign n_s2_p0 = MW'(r_s1_ar) * MW'(r_s1_br);
    assign n_s2_p1 = MW'(r_s1_ai) * MW'(r_s1_bi);
    assign n_s2_p2 = MW'(r_s1_ai) * MW'(r_s1_br);
    assign n_s2_p3 = MW'(r_s1_ar) * MW'(r_s1_bi);
    assign n_s2_p4 = MW'(sq_x) * MW'(sq_x);
    assign n_s2_p5 = MW'(sq_y) * MW'(sq_y);
    assign sum_re  = (OPW+1)'(r_s1_ar) + (OPW+1)'(r_s1_br);
    assign sum_im  = (OPW+1)'(r_s1_ai) + (OPW+1)'(r_s1_bi);
    assign dif_re  = (OPW+1)'(r_s1_ar) - (OPW+1)'(r_s1_br);
    assign dif_im  = (OPW+1)'(r_s1_ai) - (OPW+1)'(r_s1_bi);

    always_comb begin
        n_s2_ctrl        = '0;
        n_s2_ctrl.op     = r_s1_op;
        n_s2_ctrl.is_eq  = (r_s1_ar == r_s1_br) && (r_s1_ai == r_s1_bi);
        n_s2_ctrl.b_zero = (r_s1_br == '0) && (r_s1_bi == '0);
        n_s2_cre         = sat_sum(sum_re);
        n_s2_cim         = sat_sum(sum_im);
        if (r_s1_op == OP_ADD) begin
            n_s2_ctrl.sat = (sum_re[OPW] != sum_re[OPW-1]) || (sum_im[OPW] != sum_im[OPW-1]);
        end else if (r_s1_op == OP_SUB) begin
            n_s2_cre      = sat_sum(dif_re);
            n_s2_cim      = sat_sum(dif_im);
            n_s2_ctrl.sat = (dif_re[OPW] != dif_re[OPW-1]) || (dif_im[OPW] != dif_im[OPW-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_ctrl <= n_s2_ctrl;
            r_s2_cre  <= n_s2_cre;
            r_s2_cim  <= n_s2_cim;
            r_s2_p0   <= n_s2_p0;
            r_s2_p1   <= n_s2_p1;
            r_s2_p2   <= n_s2_p2;
            r_s2_p3   <= n_s2_p3;
            r_s2_p4   <= n_s2_p4;
            r_s2_p5   <= n_s2_p5;
        end
    end

    // stage 3: product sums
    logic                   r_s3_valid;
    t_ctrl                  r_s3_ctrl;
    logic signed [OPW-1:0]  r_s3_cre, r_s3_cim;
    logic signed [MW:0]     r_s3_sre, r_s3_sim, n_s3_sre, n_s3_sim;
    logic [MW-1:0]          r_s3_sq, n_s3_sq;

    always_comb begin
        if (r_s2_ctrl.op == OP_DIV) begin
            n_s3_sre = (MW+1)'(r_s2_p0) + (MW+1)'(r_s2_p1);
            n_s3_sim = (MW+1)'(r_s2_p2) - (MW+1)'(r_s2_p3);
        end else begin
            n_s3_sre = (MW+1)'(r_s2_p0) - (MW+1)'(r_s2_p1);
            n_s3_sim = (MW+1)'(r_s2_p2) + (MW+1)'(r_s2_p3);
        end
        n_s3_sq = $unsigned(r_s2_p4) + $unsigned(r_s2_p5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_ctrl <= r_s2_ctrl;
            r_s3_cre  <= r_s2_cre;
            r_s3_cim  <= r_s2_cim;
            r_s3_sre  <= n_s3_sre;
            r_s3_sim  <= n_s3_sim;
            r_s3_sq   <= n_s3_sq;
        end
    end

    // stage 4: sign and magnitude
    logic                   r_s4_valid;
    t_ctrl                  r_s4_ctrl, n_s4_ctrl;
    logic signed [OPW-1:0]  r_s4_cre, r_s4_cim;
    logic [MW-1:0]          r_s4_mag_re, r_s4_mag_im, n_s4_mag_re, n_s4_mag_im;
    logic [MW-1:0]          r_s4_sq;

    always_comb begin
        n_s4_ctrl        = r_s3_ctrl;
        n_s4_ctrl.neg_re = r_s3_sre[MW];
        n_s4_ctrl.neg_im = r_s3_sim[MW];
        n_s4_mag_re      = r_s3_sre[MW] ? MW'(-r_s3_sre) : MW'(r_s3_sre);
        n_s4_mag_im      = r_s3_sim[MW] ? MW'(-r_s3_sim) : MW'(r_s3_sim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_ctrl   <= n_s4_ctrl;
            r_s4_cre    <= r_s3_cre;
            r_s4_cim    <= r_s3_cim;
            r_s4_mag_re <= n_s4_mag_re;
            r_s4_mag_im <= n_s4_mag_im;
            r_s4_sq     <= r_s3_sq;
        end
    end

    // stage 5: multiply result, divider dividends and quotient range check
    logic                   r_s5_valid;
    t_ctrl                  r_s5_ctrl, n_s5_ctrl;
    logic signed [OPW-1:0]  r_s5_cre, r_s5_cim, n_s5_cre, n_s5_cim;
    logic [XW-1:0]          r_s5_num_re, r_s5_num_im, n_s5_num_re, n_s5_num_im;
    logic [MW-1:0]          r_s5_sq;
    logic [XW-1:0]          div_lim;
    logic [OPW:0]           mul_re, mul_im;

    assign div_lim     = XW'(r_s4_sq) << QB;
    assign n_s5_num_re = XW'(r_s4_mag_re) << FRAC_BITS;
    assign n_s5_num_im = XW'(r_s4_mag_im) << FRAC_BITS;
    assign mul_re      = clamp_mag(r_s4_ctrl.neg_re, r_s4_mag_re >> FRAC_BITS);
    assign mul_im      = clamp_mag(r_s4_ctrl.neg_im, r_s4_mag_im >> FRAC_BITS);

    always_comb begin
        n_s5_ctrl        = r_s4_ctrl;
        n_s5_ctrl.ovf_re = n_s5_num_re >= div_lim;
        n_s5_ctrl.ovf_im = n_s5_num_im >= div_lim;
        n_s5_cre         = r_s4_cre;
        n_s5_cim         = r_s4_cim;
        if (r_s4_ctrl.op == OP_MUL) begin
            n_s5_cre      = mul_re[OPW-1:0];
            n_s5_cim      = mul_im[OPW-1:0];
            n_s5_ctrl.sat = mul_re[OPW] | mul_im[OPW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_ctrl   <= n_s5_ctrl;
            r_s5_cre    <= n_s5_cre;
            r_s5_cim    <= n_s5_cim;
            r_s5_num_re <= n_s5_num_re;
            r_s5_num_im <= n_s5_num_im;
            r_s5_sq     <= r_s4_sq;
        end
    end

    assign o_valid  = r_s5_valid;
    assign o_ctrl   = r_s5_ctrl;
    assign o_cre    = r_s5_cre;
    assign o_cim    = r_s5_cim;
    assign o_den    = r_s5_sq;
    assign o_rem_re = r_s5_num_re;
    assign o_rem_im = r_s5_num_im;
    assign o_sq_s   = r_s5_sq;

endmodule

@@ rtl/cau_iter.sv @@
// One pipelined step: a quotient bit of both divisions and, while IDX is below OPW, a root bit of the square root.
module cau_iter #(
    parameter int OPW       = 32,
    parameter int FRAC_BITS = 16,
    parameter int IDX       = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  cau_pkg::t_ctrl               i_ctrl,
    input  logic signed [OPW-1:0]        i_cre,
    input  logic signed [OPW-1:0]        i_cim,
    input  logic [2*OPW-1:0]             i_den,
    input  logic [3*OPW+FRAC_BITS:0]     i_rem_re,
    input  logic [3*OPW+FRAC_BITS:0]     i_rem_im,
    input  logic [OPW:0]                 i_q_re,
    input  logic [OPW:0]                 i_q_im,
    input  logic [2*OPW-1:0]             i_sq_s,
    input  logic [2*OPW-1:0]             i_sq_r,
    output logic                         o_valid,
    output cau_pkg::t_ctrl               o_ctrl,
    output logic signed [OPW-1:0]        o_cre,
    output logic signed [OPW-1:0]        o_cim,
    output logic [2*OPW-1:0]             o_den,
    output logic [3*OPW+FRAC_BITS:0]     o_rem_re,
    output logic [3*OPW+FRAC_BITS:0]     o_rem_im,
    output logic [OPW:0]                 o_q_re,
    output logic [OPW:0]                 o_q_im,
    output logic [2*OPW-1:0]             o_sq_s,
    output logic [2*OPW-1:0]             o_sq_r
);
    import cau_pkg::*;

    localparam int MW = 2 * OPW;
    localparam int QB = OPW + 1;
    localparam int XW = 2 * OPW + FRAC_BITS + QB;

    logic [XW-1:0] dsh;
    logic [XW-1:0] n_rem_re, n_rem_im;
    logic [QB-1:0] n_q_re, n_q_im;
    logic [MW-1:0] n_sq_s, n_sq_r;

    assign dsh = XW'(i_den) << IDX;

    // restoring division step on both parts
    always_comb begin
        n_rem_re = i_rem_re;
        n_rem_im = i_rem_im;
        n_q_re   = i_q_re;
        n_q_im   = i_q_im;
        if (i_rem_re >= dsh) begin
            n_rem_re    = i_rem_re - dsh;
            n_q_re[IDX] = 1'b1;
        end
        if (i_rem_im >= dsh) begin
            n_rem_im    = i_rem_im - dsh;
            n_q_im[IDX] = 1'b1;
        end
    end

    if (IDX < OPW) begin : g_sqrt
        logic [MW-1:0] rbit, trial;
        assign rbit  = MW'(1) << (2 * IDX);
        assign trial = i_sq_r + rbit;
        always_comb begin
            if (i_sq_s >= trial) begin
                n_sq_s = i_sq_s - trial;
                n_sq_r = (i_sq_r >> 1) + rbit;
            end else begin
                n_sq_s = i_sq_s;
                n_sq_r = i_sq_r >> 1;
            end
        end
    end else begin : g_hold
        assign n_sq_s = i_sq_s;
        assign n_sq_r = i_sq_r;
    end

    logic          r_valid;
    t_ctrl         r_ctrl;
    logic signed [OPW-1:0] r_cre, r_cim;
    logic [MW-1:0] r_den, r_sq_s, r_sq_r;
    logic [XW-1:0] r_rem_re, r_rem_im;
    logic [QB-1:0] r_q_re, r_q_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl   <= i_ctrl;
            r_cre    <= i_cre;
            r_cim    <= i_cim;
            r_den    <= i_den;
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_q_re   <= n_q_re;
            r_q_im   <= n_q_im;
            r_sq_s   <= n_sq_s;
            r_sq_r   <= n_sq_r;
        end
    end

    assign o_valid  = r_valid;
    assign o_ctrl   = r_ctrl;
    assign o_cre    = r_cre;
    assign o_cim    = r_cim;
    assign o_den    = r_den;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;
    assign o_sq_s   = r_sq_s;
    assign o_sq_r   = r_sq_r;

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply, divide, modulus, compare on fixed point.
// Pipeline: five front stages, OPW + 1 divide/square-root steps, one output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a result is stalled.
// Reset (synchronous, active low) clears every valid bit; no data is cleared.
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [cau_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_a_re,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_a_im,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_b_re,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_b_im,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cau_pkg::FIELD_W-1:0]  o_res_re,
    output logic signed [cau_pkg::FIELD_W-1:0]  o_res_im,
    output logic                                o_is_equal,
    output logic [cau_pkg::STATUS_W-1:0]        o_status
);
    import cau_pkg::*;

    localparam int OPW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int MW  = 2 * OPW;
    localparam int QB  = OPW + 1;
    localparam int XW  = 2 * OPW + FRAC_BITS + QB;
    localparam logic [MW-1:0] POSLIM = {{(MW-OPW+1){1'b0}}, {(OPW-1){1'b1}}};
    localparam logic [MW-1:0] NEGLIM = {{(MW-OPW){1'b0}}, 1'b1, {(OPW-1){1'b0}}};

    // Returns {saturated, value} for a sign and magnitude.
    function automatic logic [OPW:0] clamp_mag(input logic neg, input logic [MW-1:0] mag);
        logic [OPW-1:0] low;
        low = mag[OPW-1:0];
        if (!neg && mag > POSLIM) begin
            clamp_mag = {1'b1, POSLIM[OPW-1:0]};
        end else if (neg && mag > NEGLIM) begin
            clamp_mag = {1'b1, NEGLIM[OPW-1:0]};
        end else begin
            clamp_mag = {1'b0, neg ? -low : low};
        end
    endfunction

    logic en;
    logic r_out_valid;

    // hold everything while the output transaction is stalled
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    logic                  c_valid  [QB+1];
    t_ctrl                 c_ctrl   [QB+1];
    logic signed [OPW-1:0] c_cre    [QB+1];
    logic signed [OPW-1:0] c_cim    [QB+1];
    logic [MW-1:0]         c_den    [QB+1];
    logic [XW-1:0]         c_rem_re [QB+1];
    logic [XW-1:0]         c_rem_im [QB+1];
    logic [QB-1:0]         c_q_re   [QB+1];
    logic [QB-1:0]         c_q_im   [QB+1];
    logic [MW-1:0]         c_sq_s   [QB+1];
    logic [MW-1:0]         c_sq_r   [QB+1];

    assign c_q_re[0] = '0;
    assign c_q_im[0] = '0;
    assign c_sq_r[0] = '0;

    cau_front #(
        .OPW       (OPW),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_valid  (c_valid[0]),
        .o_ctrl   (c_ctrl[0]),
        .o_cre    (c_cre[0]),
        .o_cim    (c_cim[0]),
        .o_den    (c_den[0]),
        .o_rem_re (c_rem_re[0]),
        .o_rem_im (c_rem_im[0]),
        .o_sq_s   (c_sq_s[0])
    );

    // quotient bits from the top down; step j resolves bit QB-1-j
    for (genvar j = 0; j < QB; j++) begin : g_step
        cau_iter #(
            .OPW       (OPW),
            .FRAC_BITS (FRAC_BITS),
            .IDX       (QB - 1 - j)
        ) u_iter (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (c_valid[j]),
            .i_ctrl   (c_ctrl[j]),
            .i_cre    (c_cre[j]),
            .i_cim    (c_cim[j]),
            .i_den    (c_den[j]),
            .i_rem_re (c_rem_re[j]),
            .i_rem_im (c_rem_im[j]),
            .i_q_re   (c_q_re[j]),
            .i_q_im   (c_q_im[j]),
            .i_sq_s   (c_sq_s[j]),
            .i_sq_r   (c_sq_r[j]),
            .o_valid  (c_valid[j+1]),
            .o_ctrl   (c_ctrl[j+1]),
            .o_cre    (c_cre[j+1]),
            .o_cim    (c_cim[j+1]),
            .o_den    (c_den[j+1]),
            .o_rem_re (c_rem_re[j+1]),
            .o_rem_im (c_rem_im[j+1]),
            .o_q_re   (c_q_re[j+1]),
            .o_q_im   (c_q_im[j+1]),
            .o_sq_s   (c_sq_s[j+1]),
            .o_sq_r   (c_sq_r[j+1])
        );
    end

    // result select
    t_ctrl                 last;
    logic [OPW:0]          div_re, div_im, mod_re;
    logic signed [OPW-1:0] n_res_re, n_res_im;
    logic                  n_is_equal;
    t_status               n_status;

    assign last   = c_ctrl[QB];
    assign div_re = clamp_mag(last.neg_re, last.ovf_re ? '1 : MW'(c_q_re[QB]));
    assign div_im = clamp_mag(last.neg_im, last.ovf_im ? '1 : MW'(c_q_im[QB]));
    assign mod_re = clamp_mag(1'b0, c_sq_r[QB]);

    always_comb begin
        n_res_re   = '0;
        n_res_im   = '0;
        n_is_equal = 1'b0;
        n_status   = ST_OK;
        case (last.op)
            OP_ADD, OP_SUB, OP_MUL: begin
                n_res_re = c_cre[QB];
                n_res_im = c_cim[QB];
                if (last.sat) begin
                    n_status = ST_SAT;
                end
            end
            OP_DIV: begin
                if (last.b_zero) begin
                    n_status = ST_DIVZ;
                end else begin
                    n_res_re = div_re[OPW-1:0];
                    n_res_im = div_im[OPW-1:0];
                    if (div_re[OPW] || div_im[OPW]) begin
                        n_status = ST_SAT;
                    end
                end
            end
            OP_MOD: begin
                n_res_re = mod_re[OPW-1:0];
                if (mod_re[OPW]) begin
                    n_status = ST_SAT;
                end
            end
            OP_EQ: begin
                n_is_equal = last.is_eq;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    logic signed [OPW-1:0] r_res_re, r_res_im;
    logic                  r_is_equal;
    t_status               r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_re   <= n_res_re;
            r_res_im   <= n_res_im;
            r_is_equal <= n_is_equal;
            r_status   <= n_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res_re   = FIELD_W'(r_res_re);
    assign o_res_im   = FIELD_W'(r_res_im);
    assign o_is_equal = r_is_equal;
    assign o_status   = r_status;

    `CAU_ASSERT_SAME(a_stall_only_on_held, o_stall, o_valid && i_stall, "input stalled without a held result")
    `CAU_ASSERT_NEXT(a_held_result_stays, o_stall, o_valid, "held result dropped")
    `CAU_ASSERT_SAME(a_divz_zero, o_valid && o_status == ST_DIVZ, o_res_re == '0 && o_res_im == '0, "zero divisor gave a nonzero result")
    `CAU_ASSERT_SAME(a_equal_clean, o_valid && o_is_equal, o_res_re == '0 && o_res_im == '0 && o_status == ST_OK, "compare result not clean")

endmodule
